// ===== hdl/lal_pkg.sv =====
package lal_pkg;

  localparam int PIXEL_FRAC_BITS = 24;
  localparam int LOG_FRAC_BITS   = 20;

  localparam int PIX_W   = 32;
  localparam int DIM_W   = 13;
  localparam int SUM_W   = 52;
  localparam int COUNT_W = 24;
  localparam int N_W     = COUNT_W + 1;
  localparam int LACC_W  = 48;
  localparam int XN_W    = 33;
  localparam int MANT_W  = 31;
  localparam int Z_W     = 6;
  localparam int Q_W     = SUM_W + 1;
  localparam int IP_W    = Q_W - LOG_FRAC_BITS;
  localparam int CNT_W   = 6;

  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  localparam int EPS_INT = ((2 ** PIXEL_FRAC_BITS) + 50000) / 100000;
  localparam logic [XN_W-1:0] EPS = XN_W'(EPS_INT);

  localparam logic [DIM_W-1:0] MAX_DIM   = 13'd4096;
  localparam logic [DIM_W-1:0] RST_WIDTH = 13'd1280;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd720;

  localparam int LOG_INT_BIAS   = 32 - PIXEL_FRAC_BITS;
  localparam int EXP_SHIFT_BIAS = PIXEL_FRAC_BITS - 30;

  localparam int LUM_STEPS  = 3;
  localparam int NORM_STEPS = 5;
  localparam int DIV_STEPS  = SUM_W;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic             load;
    logic             lum_step;
    logic             norm_step;
    logic             sqr_step;
    logic             accum;
    logic             div_init;
    logic             div_step;
    logic             exp_init;
    logic             exp_step;
    logic             out_load;
    logic [CNT_W-1:0] cnt;
  } lal_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic out_free;
  } lal_stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x = x_in;
    res = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > x) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  function automatic logic [MANT_W-1:0] exp2_factor(input int k);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int i = 0; i < k; i++) begin
      r = isqrt64(r << 30);
    end
    return r[MANT_W-1:0];
  endfunction

endpackage

// ===== hdl/lal_ctrl.sv =====
module lal_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  lal_pkg::lal_stat_t stat,
  output lal_pkg::lal_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LUM, S_NORM, S_SQR, S_ACC, S_DIVI, S_DIV, S_EXPI, S_EXP, S_DONE
  } state_t;

  state_t                    state;
  logic [lal_pkg::CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (pixel_valid) state <= S_LUM;
        end
        S_LUM: begin
          if (cnt == lal_pkg::CNT_W'(lal_pkg::LUM_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_NORM;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_NORM: begin
          if (cnt == lal_pkg::CNT_W'(lal_pkg::NORM_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_SQR;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQR: begin
          if (cnt == lal_pkg::CNT_W'(lal_pkg::LOG_FRAC_BITS - 1)) begin
            cnt   <= '0;
            state <= S_ACC;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ACC: begin
          state <= stat.frame_done ? S_DIVI : S_IDLE;
        end
        S_DIVI: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == lal_pkg::CNT_W'(lal_pkg::DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_EXPI;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_EXPI: begin
          cnt   <= '0;
          state <= S_EXP;
        end
        S_EXP: begin
          if (cnt == lal_pkg::CNT_W'(lal_pkg::LOG_FRAC_BITS - 1)) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.cnt       = cnt;
    cmd.load      = (state == S_IDLE) && pixel_valid;
    cmd.lum_step  = (state == S_LUM);
    cmd.norm_step = (state == S_NORM);
    cmd.sqr_step  = (state == S_SQR);
    cmd.accum     = (state == S_ACC);
    cmd.div_init  = (state == S_DIVI);
    cmd.div_step  = (state == S_DIV);
    cmd.exp_init  = (state == S_EXPI);
    cmd.exp_step  = (state == S_EXP);
    cmd.out_load  = (state == S_DONE) && stat.out_free;
  end

  assign pixel_ready = (state == S_IDLE);

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_ready) |=> (state == S_LUM && cnt == '0))
    else $error("accepted pixel did not start luminance");

  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && stat.out_free) |=> (state == S_IDLE))
    else $error("result not handed off");

  a_sqr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQR || state == S_EXP) |->
      (cnt < lal_pkg::CNT_W'(lal_pkg::LOG_FRAC_BITS)))
    else $error("step counter overrun");

  a_acc_branch: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && !stat.frame_done) |=> (state == S_IDLE))
    else $error("non-final pixel went to divide");
`endif

endmodule

// ===== hdl/lal_dp.sv =====
module lal_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  lal_pkg::lal_cmd_t                 cmd,
  output lal_pkg::lal_stat_t                stat,
  input  logic [lal_pkg::PIX_W-1:0]         red,
  input  logic [lal_pkg::PIX_W-1:0]         green,
  input  logic [lal_pkg::PIX_W-1:0]         blue,
  input  logic [lal_pkg::DIM_W-1:0]         frame_width,
  input  logic [lal_pkg::DIM_W-1:0]         frame_height,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [lal_pkg::PIX_W-1:0]         average_luminance
);

  logic [lal_pkg::PIX_W-1:0]         r_reg, g_reg, b_reg;
  logic [lal_pkg::LACC_W-1:0]        lacc;
  logic [lal_pkg::XN_W-1:0]          xn;
  logic [lal_pkg::Z_W-1:0]           z;
  logic [lal_pkg::MANT_W-1:0]        m;
  logic [lal_pkg::LOG_FRAC_BITS-1:0] frac;
  logic [lal_pkg::SUM_W-1:0]         log_sum;
  logic [lal_pkg::COUNT_W-1:0]       pixel_count;
  logic [lal_pkg::SUM_W-1:0]         div_num;
  logic [lal_pkg::N_W-1:0]           div_n;
  logic                              neg;
  logic [lal_pkg::SUM_W-1:0]         quo;
  logic [lal_pkg::COUNT_W-1:0]       rem;
  logic [lal_pkg::Q_W-1:0]           qv;
  logic [lal_pkg::MANT_W-1:0]        acc;

  logic [15:0]                       wsel;
  logic [lal_pkg::PIX_W-1:0]         csel;
  logic [lal_pkg::LACC_W-1:0]        prod;
  logic [lal_pkg::XN_W-1:0]          xsrc;
  logic [lal_pkg::Z_W-1:0]           zsrc;
  logic [lal_pkg::MANT_W-1:0]        msrc;
  logic [2*lal_pkg::MANT_W-1:0]      sq;
  logic signed [6:0]                 ipart;
  logic [lal_pkg::SUM_W-1:0]         lg;
  logic [lal_pkg::SUM_W-1:0]         sum_new;
  logic [lal_pkg::DIM_W-1:0]         wc, hc;
  logic [2*lal_pkg::DIM_W-1:0]       n_full;
  logic [lal_pkg::N_W-1:0]           n_eff;
  logic [lal_pkg::N_W-1:0]           cnt_inc;
  logic [lal_pkg::N_W-1:0]           rem2;
  logic [2*lal_pkg::MANT_W-1:0]      eprod;
  logic [lal_pkg::MANT_W-1:0]        fact_tab [lal_pkg::LOG_FRAC_BITS];
  logic [4:0]                        fidx;
  logic signed [lal_pkg::IP_W-1:0]   s2;
  logic [lal_pkg::IP_W-1:0]          s2_neg;
  logic [lal_pkg::PIX_W-1:0]         res_val;

  for (genvar i = 0; i < lal_pkg::LOG_FRAC_BITS; i++) begin : g_fact
    localparam logic [lal_pkg::MANT_W-1:0] F = lal_pkg::exp2_factor(i + 1);
    assign fact_tab[i] = F;
  end

  always_comb begin
    case (cmd.cnt[1:0])
      2'd0:    begin wsel = lal_pkg::W_RED;   csel = r_reg; end
      2'd1:    begin wsel = lal_pkg::W_GREEN; csel = g_reg; end
      default: begin wsel = lal_pkg::W_BLUE;  csel = b_reg; end
    endcase
    prod = lal_pkg::LACC_W'(wsel) * lal_pkg::LACC_W'(csel);
  end

  assign xsrc = (cmd.cnt == '0) ?
                ({1'b0, lacc[lal_pkg::LACC_W-1:16]} + lal_pkg::EPS) : xn;
  assign zsrc = (cmd.cnt == '0) ? '0 : z;
  assign msrc = (cmd.cnt == '0) ? xn[lal_pkg::XN_W-1:2] : m;
  assign sq   = (2*lal_pkg::MANT_W)'(msrc) * (2*lal_pkg::MANT_W)'(msrc);

  assign ipart   = 7'(lal_pkg::LOG_INT_BIAS) - signed'({1'b0, z});
  assign lg      = {{(lal_pkg::SUM_W - 7 - lal_pkg::LOG_FRAC_BITS){ipart[6]}}, ipart, frac};
  assign sum_new = log_sum + lg;

  always_comb begin
    wc = frame_width;
    if (frame_width == '0) wc = 13'd1;
    else if (frame_width > lal_pkg::MAX_DIM) wc = lal_pkg::MAX_DIM;
    hc = frame_height;
    if (frame_height == '0) hc = 13'd1;
    else if (frame_height > lal_pkg::MAX_DIM) hc = lal_pkg::MAX_DIM;
  end

  assign n_full  = (2*lal_pkg::DIM_W)'(wc) * (2*lal_pkg::DIM_W)'(hc);
  assign n_eff   = n_full[lal_pkg::N_W-1:0];
  assign cnt_inc = {1'b0, pixel_count} + 1'b1;
  assign stat.frame_done = (cnt_inc >= n_eff);
  assign stat.out_free   = !result_valid || result_ready;

  assign rem2  = {rem, quo[lal_pkg::SUM_W-1]};
  assign fidx  = cmd.cnt[4:0];
  assign eprod = (2*lal_pkg::MANT_W)'(acc) * (2*lal_pkg::MANT_W)'(fact_tab[fidx]);

  assign s2     = signed'(qv[lal_pkg::Q_W-1:lal_pkg::LOG_FRAC_BITS])
                  + lal_pkg::IP_W'(lal_pkg::EXP_SHIFT_BIAS);
  assign s2_neg = lal_pkg::IP_W'(-s2);

  always_comb begin
    if (s2 > 1) res_val = '1;
    else if (s2 == 1) res_val = {acc, 1'b0};
    else if (s2 == 0) res_val = {1'b0, acc};
    else if (s2 < -30) res_val = '0;
    else res_val = {1'b0, acc} >> s2_neg[4:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_reg <= red;
      g_reg <= green;
      b_reg <= blue;
      lacc  <= '0;
    end
    if (cmd.lum_step) lacc <= lacc + prod;
    if (cmd.norm_step) begin
      case (cmd.cnt[2:0])
        3'd0: begin
          if (xsrc[32:17] == '0) begin xn <= xsrc << 16; z <= zsrc + 6'd16; end
          else begin xn <= xsrc; z <= zsrc; end
        end
        3'd1: begin
          if (xsrc[32:25] == '0) begin xn <= xsrc << 8; z <= zsrc + 6'd8; end
          else begin xn <= xsrc; z <= zsrc; end
        end
        3'd2: begin
          if (xsrc[32:29] == '0) begin xn <= xsrc << 4; z <= zsrc + 6'd4; end
          else begin xn <= xsrc; z <= zsrc; end
        end
        3'd3: begin
          if (xsrc[32:31] == '0) begin xn <= xsrc << 2; z <= zsrc + 6'd2; end
          else begin xn <= xsrc; z <= zsrc; end
        end
        default: begin
          if (!xsrc[32]) begin xn <= xsrc << 1; z <= zsrc + 6'd1; end
          else begin xn <= xsrc; z <= zsrc; end
        end
      endcase
    end
    if (cmd.sqr_step) begin
      if (sq[61]) begin
        m    <= sq[61:31];
        frac <= {frac[lal_pkg::LOG_FRAC_BITS-2:0], 1'b1};
      end else begin
        m    <= sq[60:30];
        frac <= {frac[lal_pkg::LOG_FRAC_BITS-2:0], 1'b0};
      end
    end
    if (cmd.accum) begin
      div_num <= sum_new;
      div_n   <= n_eff;
    end
    if (cmd.div_init) begin
      neg <= div_num[lal_pkg::SUM_W-1];
      quo <= div_num[lal_pkg::SUM_W-1] ? -div_num : div_num;
      rem <= '0;
    end
    if (cmd.div_step) begin
      if (rem2 >= div_n) begin
        rem <= lal_pkg::COUNT_W'(rem2 - div_n);
        quo <= {quo[lal_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem2[lal_pkg::COUNT_W-1:0];
        quo <= {quo[lal_pkg::SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.exp_init) begin
      qv  <= neg ? (~{1'b0, quo} + lal_pkg::Q_W'(rem == '0)) : {1'b0, quo};
      acc <= lal_pkg::MANT_W'(1) << 30;
    end
    if (cmd.exp_step && qv[lal_pkg::LOG_FRAC_BITS - 1 - fidx]) begin
      acc <= eprod[60:30];
    end
    if (cmd.out_load) average_luminance <= res_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log_sum      <= '0;
      pixel_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.accum) begin
        if (stat.frame_done) begin
          log_sum     <= '0;
          pixel_count <= '0;
        end else begin
          log_sum     <= sum_new;
          pixel_count <= cnt_inc[lal_pkg::COUNT_W-1:0];
        end
      end
      if (cmd.out_load) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/log_average_luminance.sv =====
// Log-average (geometric mean) luminance of a frame, Rec.709 weights.
// Pixel channel: pixel_valid/pixel_ready with red, green, blue in
// unsigned Q8.24. One transaction per pixel.
// Result channel: result_valid/result_ready with average_luminance in
// unsigned Q8.24, one transaction per completed frame (width * height px).
// Config: APB, frame_width at 0x0, frame_height at 0x4, write when idle.
// Each pixel passes, from acceptance to the next acceptance, through
// 3 multiply-accumulate steps for luminance, 5 normalize steps and 20
// square-and-compare steps of the log2 unit and one accumulate step.
// The frame's last pixel goes on to a 52-step restoring divider,
// 20 multiply steps of the exp2 unit and the output load.
// The result sits in an output register; the next frame's pixels are
// taken while it waits. If it is still untaken when the next frame
// ends, the block holds in that state until result_ready.
// Reset clears the running sum, the pixel count and result_valid and
// restores the dimensions to 1280 x 720.
module log_average_luminance (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  logic [31:0] red,
  input  logic [31:0] green,
  input  logic [31:0] blue,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] average_luminance,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [lal_pkg::DIM_W-1:0] frame_width;
  logic [lal_pkg::DIM_W-1:0] frame_height;
  lal_pkg::lal_cmd_t         cmd;
  lal_pkg::lal_stat_t        stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lal_pkg::RST_WIDTH;
      frame_height <= lal_pkg::RST_HEIGHT;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        lal_pkg::REG_WIDTH:  frame_width  <= pwdata[lal_pkg::DIM_W-1:0];
        lal_pkg::REG_HEIGHT: frame_height <= pwdata[lal_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lal_pkg::REG_WIDTH:  prdata = {19'b0, frame_width};
      lal_pkg::REG_HEIGHT: prdata = {19'b0, frame_height};
      default:             prdata = '0;
    endcase
  end

  lal_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  lal_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .red               (red),
    .green             (green),
    .blue              (blue),
    .frame_width       (frame_width),
    .frame_height      (frame_height),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .average_luminance (average_luminance)
  );

endmodule
